FILE: src/scta_pkg.sv
// ----------------------------------------------------------------------------
// scta_pkg
// Shared types, request codes, scancode constants and the set-1 keymaps for
// the scancode to ascii line buffer.
// ----------------------------------------------------------------------------
package scta_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int KEYMAP_ENTRIES   = 128;
    localparam int KEYMAP_USED      = 58;

    localparam int REQ_W  = 2;
    localparam int CODE_W = 8;
    localparam int CHAR_W = 8;
    localparam int FILL_W = 7;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_SCAN  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    localparam logic [CODE_W-1:0] KEY_NONE      = 8'h00;
    localparam logic [CODE_W-1:0] KEY_BACKSPACE = 8'h0E;
    localparam logic [CODE_W-1:0] KEY_LSHIFT    = 8'h2A;
    localparam logic [CODE_W-1:0] KEY_RSHIFT    = 8'h36;
    localparam logic [CODE_W-1:0] KEY_CAPS      = 8'h3A;
    localparam logic [CODE_W-1:0] KEY_UP        = 8'h48;
    localparam logic [CODE_W-1:0] KEY_LEFT      = 8'h4B;
    localparam logic [CODE_W-1:0] KEY_RIGHT     = 8'h4D;
    localparam logic [CODE_W-1:0] KEY_DOWN      = 8'h50;
    localparam logic [CODE_W-1:0] RELEASE_MASK  = 8'h80;

    localparam logic [CHAR_W-1:0] CHAR_EMPTY = 8'hFF;

    typedef struct packed {
        logic [FILL_W-1:0] fill_count;
        logic              read_empty;
        logic [CHAR_W-1:0] char_out;
    } result_t;

    localparam logic [CHAR_W-1:0] KEYMAP_LOWER [KEYMAP_USED] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [CHAR_W-1:0] KEYMAP_UPPER [KEYMAP_USED] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    function automatic logic [CHAR_W-1:0] keymap_lookup(
        input logic [CODE_W-2:0] code,
        input logic              upper
    );
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if ({1'b0, code} < 8'(KEYMAP_ENTRIES) && code < 7'(KEYMAP_USED))
        begin
            ch = upper ? KEYMAP_UPPER[code[5:0]] : KEYMAP_LOWER[code[5:0]];
        end
        return ch;
    endfunction

endpackage

FILE: src/scta_ram.sv
// ----------------------------------------------------------------------------
// scta_ram
// Generic single-clock ram, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module scta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/scancode_to_ascii_line_buffer_core.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_buffer_core
// Set-1 keyboard scancode to ascii character queue.
//
// Input beats (s_*) carry a request kind in s_tuser: a scancode event, a read
// of one character or a clear. Each input beat gives exactly one output beat
// (m_*) with an empty flag, the fill count and, for a read, the popped character.
// Characters live in a ring ram of BUFFER_DEPTH bytes; shift and caps lock
// are kept in flops and select the lowercase or uppercase keymap.
// The output beat is registered; a read that finds a character first passes
// through S_READ, since the ring ram has a registered read port.
// Throughput: one beat per cycle, but s_tready is low in S_READ and while a
// result is parked, so a read that finds a character holds off the next beat.
// Reset clears pointers, fill count, shift and caps lock and the output
// stage; the ring contents are not cleared and need no sweep.
// When the receiver stalls, one more input beat is taken and its result is
// parked in a second output register; s_tready then drops until m_tready.
// ----------------------------------------------------------------------------
module scancode_to_ascii_line_buffer_core #(
    parameter int BUFFER_DEPTH = scta_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scta_pkg::CODE_W-1:0]        s_tdata,   // scancode
    input  logic [scta_pkg::REQ_W-1:0]         s_tuser,   // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scta_pkg::OUT_DATA_W-1:0]    m_tdata,   // char_out, fill_count, pad
    output logic [0:0]                         m_tuser    // read_empty
);

    import scta_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic              shift_reg, shift_next;
    logic              caps_reg, caps_next;
    logic              out_valid_reg, out_valid_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           out_reg, out_next;
    result_t           pend_reg, pend_next;

    logic              s_acc;
    logic              out_free;
    logic              new_valid;
    result_t           new_res;
    logic              ram_we;
    logic              ram_re;
    logic [CHAR_W-1:0] ram_wdata;
    logic [CHAR_W-1:0] ram_rdata;
    logic [CODE_W-1:0] code;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    assign code     = s_tdata;
    assign s_tready = (state_reg == S_IDLE) && !pend_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    scta_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rp_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        held_next  = held_reg;
        shift_next = shift_reg;
        caps_next  = caps_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_wdata  = keymap_lookup(code[CODE_W-2:0], shift_reg ^ caps_reg);
        new_valid  = 1'b0;
        new_res    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    new_valid = 1'b1;
                    unique case (req_t'(s_tuser))
                        REQ_SCAN:
                        begin
                            if (code == KEY_BACKSPACE)
                            begin
                                if (held_reg != '0)
                                begin
                                    wp_next   = ptr_dec(wp_reg);
                                    held_next = held_reg - 1'b1;
                                end
                            end
                            else if (code == KEY_UP || code == KEY_LEFT ||
                                     code == KEY_RIGHT || code == KEY_DOWN ||
                                     code == KEY_NONE)
                            begin
                                held_next = held_reg;
                            end
                            else if (code == (KEY_LSHIFT | RELEASE_MASK) ||
                                     code == (KEY_RSHIFT | RELEASE_MASK))
                            begin
                                shift_next = 1'b0;
                            end
                            else if ((code & RELEASE_MASK) != '0)
                            begin
                                held_next = held_reg;
                            end
                            else if (code == KEY_LSHIFT || code == KEY_RSHIFT)
                            begin
                                shift_next = 1'b1;
                            end
                            else if (code == KEY_CAPS)
                            begin
                                caps_next = !caps_reg;
                            end
                            else
                            begin
                                ram_we  = 1'b1;
                                wp_next = ptr_inc(wp_reg);
                                if (held_reg == FULL_CNT)
                                begin
                                    rp_next = ptr_inc(rp_reg);
                                end
                                else
                                begin
                                    held_next = held_reg + 1'b1;
                                end
                            end
                        end
                        REQ_READ:
                        begin
                            if (held_reg == '0)
                            begin
                                new_res.char_out   = CHAR_EMPTY;
                                new_res.read_empty = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                rp_next    = ptr_inc(rp_reg);
                                held_next  = held_reg - 1'b1;
                                new_valid  = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            held_next = '0;
                            rp_next   = '0;
                            wp_next   = '0;
                        end
                        default:
                        begin
                            held_next = held_reg;
                        end
                    endcase
                    new_res.fill_count = FILL_W'(held_next);
                end
            end
            S_READ:
            begin
                new_valid          = 1'b1;
                new_res.char_out   = ram_rdata;
                new_res.fill_count = FILL_W'(held_reg);
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // two-entry output stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = new_valid;
                pend_next       = new_res;
            end
            else
            begin
                out_valid_next = new_valid;
                out_next       = new_res;
            end
        end
        else if (new_valid)
        begin
            pend_valid_next = 1'b1;
            pend_next       = new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            held_reg       <= '0;
            shift_reg      <= 1'b0;
            caps_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            held_reg       <= held_next;
            shift_reg      <= shift_next;
            caps_reg       <= caps_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_reg.fill_count, out_reg.char_out});
    assign m_tuser  = out_reg.read_empty;

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("parked result without a result on the output");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= FULL_CNT)
        else $error("fill count above ring depth");

    a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tuser == REQ_READ && held_reg != '0) |=> state_reg == S_READ)
        else $error("read of a held character did not wait for ram data");

    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_IDLE && (out_valid_reg || pend_valid_reg))
        else $error("read result not delivered after ram access");

    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !s_tready)
        else $error("input taken while a read is in flight");

endmodule
